[rtl/lpe_pkg.sv]
// shared constants, types and arithmetic helpers for the longest edge search
`default_nettype none

package lpe_pkg;

   // store size and the widths that follow from it
   localparam int MAX_CORNERS = 1024;
   localparam int COUNT_W     = $clog2(MAX_CORNERS + 1);
   localparam int IDX_W       = (MAX_CORNERS > 2) ? $clog2(MAX_CORNERS) : 1;

   // fixed field widths
   localparam int COORD_W     = 16;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int SQ_W        = 2 * DIFF_W - 1;
   localparam int LEN_W       = SQ_W + 1;
   localparam int OUT_INDEX_W = 10;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_CORNERS);
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_TWO = COUNT_W'(2);

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // item after the corner tracking stage
   typedef struct packed {
      logic                     last;
      logic                     edge_valid;
      logic                     close_valid;
      status_type               status;
      logic [IDX_W-1:0]         index;
      logic signed [DIFF_W-1:0] edge_dx;
      logic signed [DIFF_W-1:0] edge_dy;
      logic signed [DIFF_W-1:0] close_dx;
      logic signed [DIFF_W-1:0] close_dy;
   } diff_type;

   // item after the squaring stage
   typedef struct packed {
      logic             last;
      logic             edge_valid;
      logic             close_valid;
      status_type       status;
      logic [IDX_W-1:0] index;
      logic [SQ_W-1:0]  edge_sx;
      logic [SQ_W-1:0]  edge_sy;
      logic [SQ_W-1:0]  close_sx;
      logic [SQ_W-1:0]  close_sy;
   } square_type;

   // exact signed difference of two coordinates
   function automatic logic signed [DIFF_W-1:0] coord_diff(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
   endfunction

   // square of a difference, always non-negative
   function automatic logic [SQ_W-1:0] diff_square(input logic signed [DIFF_W-1:0] d);
      logic signed [2*DIFF_W-1:0] p;
      p = d * d;
      return p[SQ_W-1:0];
   endfunction

   // sum of two squares
   function automatic logic [LEN_W-1:0] len_sum(
      input logic [SQ_W-1:0] a,
      input logic [SQ_W-1:0] b
   );
      return {1'b0, a} + {1'b0, b};
   endfunction

   // corner index onto the result field width
   function automatic logic [OUT_INDEX_W-1:0] out_index(input logic [IDX_W-1:0] i);
      return OUT_INDEX_W'(i);
   endfunction

endpackage

`default_nettype wire

[rtl/lpe_track.sv]
// corner tracking stage: first and previous corner, count, edge differences
`default_nettype none

module lpe_track (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            closed_polygon,
   input  wire logic                            in_take,
   input  wire logic signed [lpe_pkg::COORD_W-1:0] in_x,
   input  wire logic signed [lpe_pkg::COORD_W-1:0] in_y,
   input  wire logic                            in_last,
   input  wire logic                            out_take,
   output lpe_pkg::diff_type                    out_data,
   output logic                                 out_valid
);

   logic signed [lpe_pkg::COORD_W-1:0] first_x_ff, first_x_in;
   logic signed [lpe_pkg::COORD_W-1:0] first_y_ff, first_y_in;
   logic signed [lpe_pkg::COORD_W-1:0] prev_x_ff, prev_x_in;
   logic signed [lpe_pkg::COORD_W-1:0] prev_y_ff, prev_y_in;
   logic [lpe_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                               overflowed_ff, overflowed_in;
   logic                               valid_ff, valid_in;
   lpe_pkg::diff_type                  data_ff, data_in;

   logic                               in_range;
   logic                               first_corner;
   logic signed [lpe_pkg::COORD_W-1:0] new_first_x, new_first_y;
   logic signed [lpe_pkg::COORD_W-1:0] new_prev_x, new_prev_y;
   logic [lpe_pkg::COUNT_W-1:0]        new_count;
   logic                               new_overflowed;

   // corner bookkeeping for this item
   always_comb begin
      in_range       = (count_ff < lpe_pkg::MAX_COUNT);
      first_corner   = (count_ff == '0);
      new_first_x    = (in_range && first_corner) ? in_x : first_x_ff;
      new_first_y    = (in_range && first_corner) ? in_y : first_y_ff;
      new_prev_x     = in_range ? in_x : prev_x_ff;
      new_prev_y     = in_range ? in_y : prev_y_ff;
      new_count      = in_range ? count_ff + lpe_pkg::COUNT_ONE : count_ff;
      new_overflowed = overflowed_ff | ~in_range;
   end

   // differences and status for the next stage
   always_comb begin
      data_in             = data_ff;
      data_in.last        = in_last;
      data_in.edge_valid  = in_range && !first_corner;
      data_in.close_valid = in_last && closed_polygon;
      data_in.index       = lpe_pkg::IDX_W'(new_count - lpe_pkg::COUNT_ONE);
      data_in.edge_dx     = lpe_pkg::coord_diff(prev_x_ff, in_x);
      data_in.edge_dy     = lpe_pkg::coord_diff(prev_y_ff, in_y);
      data_in.close_dx    = lpe_pkg::coord_diff(new_prev_x, new_first_x);
      data_in.close_dy    = lpe_pkg::coord_diff(new_prev_y, new_first_y);
      if (new_overflowed) begin
         data_in.status = lpe_pkg::STATUS_OVERFLOW;
      end else if (new_count < lpe_pkg::COUNT_TWO) begin
         data_in.status = lpe_pkg::STATUS_SHORT;
      end else begin
         data_in.status = lpe_pkg::STATUS_OK;
      end
   end

   // next state: a last corner starts a fresh polygon
   always_comb begin
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      count_in      = count_ff;
      overflowed_in = overflowed_ff;
      if (in_take) begin
         if (in_last) begin
            first_x_in    = '0;
            first_y_in    = '0;
            prev_x_in     = '0;
            prev_y_in     = '0;
            count_in      = '0;
            overflowed_in = 1'b0;
         end else begin
            first_x_in    = new_first_x;
            first_y_in    = new_first_y;
            prev_x_in     = new_prev_x;
            prev_y_in     = new_prev_y;
            count_in      = new_count;
            overflowed_in = new_overflowed;
         end
      end
      if (in_take) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         count_ff      <= '0;
         overflowed_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         first_x_ff    <= first_x_in;
         first_y_ff    <= first_y_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         count_ff      <= count_in;
         overflowed_ff <= overflowed_in;
         valid_ff      <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (in_take) begin
         data_ff <= data_in;
      end
   end

   assign out_data  = data_ff;
   assign out_valid = valid_ff;

endmodule

`default_nettype wire

[rtl/lpe_square.sv]
// squaring stage: four squares of the edge and closing edge differences
`default_nettype none

module lpe_square (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_take,
   input  wire lpe_pkg::diff_type in_data,
   input  wire logic              out_take,
   output lpe_pkg::square_type    out_data,
   output logic                   out_valid
);

   logic                 valid_ff, valid_in;
   lpe_pkg::square_type  data_ff, data_in;

   // one multiplier per difference
   always_comb begin
      data_in.last        = in_data.last;
      data_in.edge_valid  = in_data.edge_valid;
      data_in.close_valid = in_data.close_valid;
      data_in.status      = in_data.status;
      data_in.index       = in_data.index;
      data_in.edge_sx     = lpe_pkg::diff_square(in_data.edge_dx);
      data_in.edge_sy     = lpe_pkg::diff_square(in_data.edge_dy);
      data_in.close_sx    = lpe_pkg::diff_square(in_data.close_dx);
      data_in.close_sy    = lpe_pkg::diff_square(in_data.close_dy);
   end

   // stage occupancy
   always_comb begin
      if (in_take) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         data_ff <= data_in;
      end
   end

   assign out_data  = data_ff;
   assign out_valid = valid_ff;

endmodule

`default_nettype wire

[rtl/lpe_select.sv]
// selection stage: running best edge and the result register
`default_nettype none

module lpe_select (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire lpe_pkg::square_type                 in_data,
   output logic                                     in_take,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [lpe_pkg::OUT_INDEX_W-1:0]          rsp_best_index,
   output logic [1:0]                               rsp_status
);

   logic [lpe_pkg::LEN_W-1:0]       best_len_ff, best_len_in;
   logic [lpe_pkg::IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lpe_pkg::OUT_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   lpe_pkg::status_type             rsp_status_ff, rsp_status_in;

   logic                            out_free;
   logic [lpe_pkg::LEN_W-1:0]       edge_len, close_len;
   logic                            edge_win, close_win;
   logic [lpe_pkg::LEN_W-1:0]       after_len;
   logic [lpe_pkg::IDX_W-1:0]       after_idx;

   // a last item needs the result register, others pass freely
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign in_take  = in_valid && (!in_data.last || out_free);

   // compare both edges against the running best in parallel
   // index is the closing edge start, the incoming edge starts one corner earlier
   always_comb begin
      edge_len  = lpe_pkg::len_sum(in_data.edge_sx, in_data.edge_sy);
      close_len = lpe_pkg::len_sum(in_data.close_sx, in_data.close_sy);
      edge_win  = in_data.edge_valid && (edge_len > best_len_ff);
      close_win = in_data.close_valid && (close_len > best_len_ff)
                  && (!edge_win || (close_len > edge_len));
      if (close_win) begin
         after_len = close_len;
         after_idx = in_data.index;
      end else if (edge_win) begin
         after_len = edge_len;
         after_idx = in_data.index - lpe_pkg::IDX_W'(1);
      end else begin
         after_len = best_len_ff;
         after_idx = best_idx_ff;
      end
   end

   // best update and result capture
   always_comb begin
      best_len_in   = best_len_ff;
      best_idx_in   = best_idx_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (in_take) begin
         if (in_data.last) begin
            best_len_in   = '0;
            best_idx_in   = '0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = in_data.status;
            if (in_data.status == lpe_pkg::STATUS_OK) begin
               rsp_index_in = lpe_pkg::out_index(after_idx);
            end else begin
               rsp_index_in = '0;
            end
         end else begin
            best_len_in = after_len;
            best_idx_in = after_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_len_ff  <= '0;
         best_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_len_ff  <= best_len_in;
         best_idx_ff  <= best_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_index = rsp_index_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

[rtl/longest_polygon_edge_index.sv]
// Longest polygon edge search: one corner item per cycle unless stalled, three register stages.
// After the last corner is accepted it passes the tracking, squaring and result registers in turn.
// Throughput: one corner per cycle while no last corner waits on a stalled result.
// A stalled result holds only the result register; other corners keep flowing, a last corner waits.
// Reset is synchronous, active high: clears the polygon state, closed_polygon = 1.
`default_nettype none

module longest_polygon_edge_index (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [lpe_pkg::COORD_W-1:0]     req_x,
   input  wire logic signed [lpe_pkg::COORD_W-1:0]     req_y,
   input  wire logic                                   req_last,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [lpe_pkg::OUT_INDEX_W-1:0]             rsp_best_index,
   output logic [1:0]                                  rsp_status,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic                                   csr_closed_polygon
);

   logic                closed_ff, closed_in;
   logic                req_take;
   logic                s1_valid, s1_take;
   logic                s2_valid, s2_take;
   lpe_pkg::diff_type   s1_data;
   lpe_pkg::square_type s2_data;

   // configuration register
   assign csr_ready = 1'b1;
   assign closed_in = (csr_valid && csr_ready) ? csr_closed_polygon : closed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= 1'b1;
      end else begin
         closed_ff <= closed_in;
      end
   end

   // stage handshakes: a stage moves on when the next one has room
   assign s1_take   = s1_valid && (!s2_valid || s2_take);
   assign req_stall = s1_valid && !s1_take;
   assign req_take  = req_valid && !req_stall;

   lpe_track u_track (
      .clock          (clock),
      .reset          (reset),
      .closed_polygon (closed_ff),
      .in_take        (req_take),
      .in_x           (req_x),
      .in_y           (req_y),
      .in_last        (req_last),
      .out_take       (s1_take),
      .out_data       (s1_data),
      .out_valid      (s1_valid)
   );

   lpe_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_take   (s1_take),
      .in_data   (s1_data),
      .out_take  (s2_take),
      .out_data  (s2_data),
      .out_valid (s2_valid)
   );

   lpe_select u_select (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s2_valid),
      .in_data        (s2_data),
      .in_take        (s2_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_index (rsp_best_index),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire
